// File: rtl/core/assert_macros.svh
// Assertion macros for the supervisor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Implication or plain property checked on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Condition that must never be seen outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif

`endif

// File: rtl/core/ips_pkg.sv
// Shared types and constants of the inverter power stage supervisor.
`default_nettype none
package ips_pkg;

   localparam int DUTY_BITS        = 16;
   localparam int COMPARE_BITS_DEF = 16;
   localparam int CSR_IDX_BITS     = 2;
   localparam int QUEUE_DEPTH      = 2;

   localparam logic [CSR_IDX_BITS-1:0] CSR_PWM_PERIOD   = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_START_DUTY_U = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_START_DUTY_V = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_START_DUTY_W = 2'd3;

   localparam logic [DUTY_BITS-1:0] PERIOD_RST  = 16'd8399;
   localparam logic [DUTY_BITS-1:0] START_U_RST = 16'd2100;
   localparam logic [DUTY_BITS-1:0] START_V_RST = 16'd4200;
   localparam logic [DUTY_BITS-1:0] START_W_RST = 16'd6300;

   localparam logic [2:0] F_TIMER   = 3'b001;
   localparam logic [2:0] F_STARTUP = 3'b010;
   localparam logic [2:0] F_BREAK   = 3'b100;

   typedef enum logic [2:0] {
      CMD_INIT        = 3'd0,
      CMD_READY       = 3'd1,
      CMD_START       = 3'd2,
      CMD_STOP        = 3'd3,
      CMD_SET_DUTY    = 3'd4,
      CMD_CLEAR_FAULT = 3'd5,
      CMD_BREAK       = 3'd6,
      CMD_READY_START = 3'd7
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_ERROR     = 3'd1,
      ST_FAULT     = 3'd2,
      ST_BAD_STATE = 3'd3,
      ST_BAD_DUTY  = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      M_SAFE_OFF = 3'd0,
      M_READY    = 3'd1,
      M_STARTING = 3'd2,
      M_RUNNING  = 3'd3,
      M_STOPPING = 3'd4,
      M_FAULT    = 3'd5
   } mode_type;

   typedef struct packed {
      logic [2:0]           command;
      logic [DUTY_BITS-1:0] duty_u;
      logic [DUTY_BITS-1:0] duty_v;
      logic [DUTY_BITS-1:0] duty_w;
      logic                 timer_fail;
      logic                 break_active;
   } req_type;

   typedef struct packed {
      logic [2:0]           status;
      logic [2:0]           mode;
      logic [2:0]           fault_bits;
      logic                 gate_on;
      logic                 pwm_on;
      logic [DUTY_BITS-1:0] compare_u_out;
      logic [DUTY_BITS-1:0] compare_v_out;
      logic [DUTY_BITS-1:0] compare_w_out;
   } rsp_type;

   // Classified command as it waits between front and back.
   typedef struct packed {
      cmd_type              cmd;
      logic [DUTY_BITS-1:0] duty_u;
      logic [DUTY_BITS-1:0] duty_v;
      logic [DUTY_BITS-1:0] duty_w;
      logic                 duty_ok;
      logic                 timer_fail;
      logic                 break_active;
   } op_type;

   typedef struct packed {
      logic [DUTY_BITS-1:0] pwm_period;
      logic [DUTY_BITS-1:0] start_duty_u;
      logic [DUTY_BITS-1:0] start_duty_v;
      logic [DUTY_BITS-1:0] start_duty_w;
   } cfg_type;

   typedef struct packed {
      logic push;
      logic full;
   } qwr_type;

   typedef struct packed {
      logic pop;
      logic valid;
   } qrd_type;

endpackage
`default_nettype wire

// File: rtl/core/ips_chan_if.sv
// Valid/ready channel carrying one payload item.
`default_nettype none
interface ips_chan_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/ips_front.sv
// Front end: accepts commands, decodes them and checks duties against the period.
`default_nettype none
module ips_front (
   ips_chan_if.sink                   req_ch,
   input  logic [ips_pkg::DUTY_BITS-1:0] pwm_period,
   input  logic                       q_full,
   output ips_pkg::qwr_type           qwr,
   output ips_pkg::op_type            op
);
   import ips_pkg::*;

   assign req_ch.ready = !q_full;
   assign qwr.push     = req_ch.valid && !q_full;
   assign qwr.full     = q_full;

   always_comb begin
      op.cmd          = cmd_type'(req_ch.data.command);
      op.duty_u       = req_ch.data.duty_u;
      op.duty_v       = req_ch.data.duty_v;
      op.duty_w       = req_ch.data.duty_w;
      op.timer_fail   = req_ch.data.timer_fail;
      op.break_active = req_ch.data.break_active;
      // user keeps config static while items in flight (not enforced), check here
      op.duty_ok      = (req_ch.data.duty_u <= pwm_period) &&
                        (req_ch.data.duty_v <= pwm_period) &&
                        (req_ch.data.duty_w <= pwm_period);
   end
endmodule
`default_nettype wire

// File: rtl/core/ips_queue.sv
// Short FIFO of classified commands between front and back.
`default_nettype none
module ips_queue (
   input  logic            clock,
   input  logic            reset,
   input  ips_pkg::qwr_type qwr,
   input  ips_pkg::op_type  wr_op,
   output logic            full,
   input  logic            pop,
   output ips_pkg::qrd_type qrd,
   output ips_pkg::op_type  rd_op
);
   import ips_pkg::*;

   localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(QUEUE_DEPTH - 1);

   op_type              mem_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign full      = (count_ff == CNT_BITS'(QUEUE_DEPTH));
   assign qrd.valid = (count_ff != '0);
   assign qrd.pop   = do_pop;
   assign rd_op     = mem_ff[rd_ptr_ff];
   assign do_push   = qwr.push && !qwr.full;
   assign do_pop    = pop && qrd.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_op;
      end
   end
endmodule
`default_nettype wire

// File: rtl/core/ips_back.sv
// Back end: supervisor state update and registered result output.
`default_nettype none
module ips_back #(
   parameter int COMPARE_BITS = ips_pkg::COMPARE_BITS_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  ips_pkg::cfg_type cfg,
   input  ips_pkg::qrd_type qrd,
   input  ips_pkg::op_type  op,
   output logic            pop,
   ips_chan_if.source      rsp_ch
);
   import ips_pkg::*;

   localparam int CMP_WIDE = (COMPARE_BITS > DUTY_BITS) ? COMPARE_BITS : DUTY_BITS;

   mode_type                mode_ff, mode_in;
   logic [2:0]              fault_ff, fault_in;
   logic                    gate_ff, gate_in;
   logic                    pwm_ff, pwm_in;
   logic [COMPARE_BITS-1:0] cmp_u_ff, cmp_u_in;
   logic [COMPARE_BITS-1:0] cmp_v_ff, cmp_v_in;
   logic [COMPARE_BITS-1:0] cmp_w_ff, cmp_w_in;
   status_type              status;
   logic                    go_start;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;

   function automatic logic [COMPARE_BITS-1:0] to_cmp(input logic [DUTY_BITS-1:0] v);
      logic [CMP_WIDE-1:0] w;
      w = CMP_WIDE'(v);
      return w[COMPARE_BITS-1:0];
   endfunction

   function automatic logic [DUTY_BITS-1:0] to_out(input logic [COMPARE_BITS-1:0] v);
      logic [CMP_WIDE-1:0] w;
      w = CMP_WIDE'(v);
      return w[DUTY_BITS-1:0];
   endfunction

   assign pop = qrd.valid && (!rsp_valid_ff || rsp_ch.ready);

   always_comb begin
      mode_in  = mode_ff;
      fault_in = fault_ff;
      gate_in  = gate_ff;
      pwm_in   = pwm_ff;
      cmp_u_in = cmp_u_ff;
      cmp_v_in = cmp_v_ff;
      cmp_w_in = cmp_w_ff;
      status   = ST_OK;
      // ready-then-start goes straight through ready when coming from safe off
      go_start = (op.cmd == CMD_START) ? (mode_ff == M_READY) : (mode_ff == M_SAFE_OFF);
      case (op.cmd)
         CMD_INIT: begin
            mode_in  = M_SAFE_OFF;
            fault_in = '0;
            gate_in  = 1'b0;
            pwm_in   = 1'b0;
            if (op.timer_fail) begin
               fault_in = F_TIMER;
               mode_in  = M_FAULT;
               status   = ST_ERROR;
            end
         end
         CMD_READY: begin
            if (fault_ff != '0) begin
               status = ST_FAULT;
            end else if (mode_ff == M_SAFE_OFF) begin
               mode_in = M_READY;
            end else begin
               status = ST_BAD_STATE;
            end
         end
         CMD_START, CMD_READY_START: begin
            if (fault_ff != '0) begin
               status = ST_FAULT;
            end else if (go_start) begin
               cmp_u_in = to_cmp(cfg.start_duty_u);
               cmp_v_in = to_cmp(cfg.start_duty_v);
               cmp_w_in = to_cmp(cfg.start_duty_w);
               if (op.timer_fail) begin
                  gate_in  = 1'b0;
                  pwm_in   = 1'b0;
                  fault_in = fault_ff | F_TIMER | F_STARTUP;
                  mode_in  = M_FAULT;
                  status   = ST_ERROR;
               end else begin
                  gate_in = 1'b1;
                  pwm_in  = 1'b1;
                  mode_in = M_RUNNING;
               end
            end else begin
               status = ST_BAD_STATE;
            end
         end
         CMD_STOP: begin
            gate_in = 1'b0;
            pwm_in  = 1'b0;
            if (op.timer_fail) begin
               fault_in = fault_ff | F_TIMER;
               mode_in  = M_FAULT;
               status   = ST_ERROR;
            end else if (mode_ff == M_FAULT) begin
               status = ST_FAULT;
            end else if (mode_ff inside {[M_SAFE_OFF:M_STOPPING]}) begin
               mode_in = M_SAFE_OFF;
            end else begin
               status = ST_BAD_STATE;
            end
         end
         CMD_SET_DUTY: begin
            if (mode_ff != M_RUNNING) begin
               status = ST_BAD_STATE;
            end else if (!op.duty_ok) begin
               status = ST_BAD_DUTY;
            end else begin
               cmp_u_in = to_cmp(op.duty_u);
               cmp_v_in = to_cmp(op.duty_v);
               cmp_w_in = to_cmp(op.duty_w);
            end
         end
         CMD_CLEAR_FAULT: begin
            if (mode_ff != M_FAULT) begin
               status = ST_BAD_STATE;
            end else if (op.break_active) begin
               status = ST_FAULT;
            end else begin
               gate_in = 1'b0;
               pwm_in  = 1'b0;
               if (op.timer_fail) begin
                  fault_in = fault_ff | F_TIMER;
                  status   = ST_ERROR;
               end else begin
                  fault_in = '0;
                  mode_in  = M_SAFE_OFF;
               end
            end
         end
         CMD_BREAK: begin
            fault_in = fault_ff | F_BREAK;
            mode_in  = M_FAULT;
            gate_in  = 1'b0;
            pwm_in   = 1'b0;
         end
         default: begin
            status = ST_BAD_STATE;
         end
      endcase

      rsp_in.status        = status;
      rsp_in.mode          = mode_in;
      rsp_in.fault_bits    = fault_in;
      rsp_in.gate_on       = gate_in;
      rsp_in.pwm_on        = pwm_in;
      rsp_in.compare_u_out = to_out(cmp_u_in);
      rsp_in.compare_v_out = to_out(cmp_v_in);
      rsp_in.compare_w_out = to_out(cmp_w_in);

      rsp_valid_in = rsp_valid_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= M_SAFE_OFF;
         fault_ff     <= '0;
         gate_ff      <= 1'b0;
         pwm_ff       <= 1'b0;
         cmp_u_ff     <= '0;
         cmp_v_ff     <= '0;
         cmp_w_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (qrd.pop) begin
            mode_ff  <= mode_in;
            fault_ff <= fault_in;
            gate_ff  <= gate_in;
            pwm_ff   <= pwm_in;
            cmp_u_ff <= cmp_u_in;
            cmp_v_ff <= cmp_v_in;
            cmp_w_ff <= cmp_w_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (qrd.pop) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_ff;
endmodule
`default_nettype wire

// File: rtl/core/inverter_power_stage_supervisor_unit.sv
// Top level of the inverter power stage supervisor.
// Takes one command item per cycle while the queue has room, and returns one status
// item for each, in order. An accepted item is written into the queue, then taken by
// the back end, which registers its result for rsp_ch. Throughput, set by the back
// end's mode/fault update, is one item per cycle while neither side stalls. A
// two-entry queue between the decoding front end and the back end, and the registered
// result, let either side stall independently; req_ch.ready drops only when it is full.
// Configuration (period and start duties) is to be written through csr_* while idle; the block has no check on it.
// COMPARE_BITS sets the width of the stored compare values.
`default_nettype none
`include "assert_macros.svh"
module inverter_power_stage_supervisor_unit #(
   parameter int COMPARE_BITS = ips_pkg::COMPARE_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   ips_chan_if.sink                         req_ch,
   ips_chan_if.source                       rsp_ch,
   input  logic                             csr_write,
   input  logic [ips_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [ips_pkg::DUTY_BITS-1:0]    csr_data
);
   import ips_pkg::*;

   cfg_type cfg_ff, cfg_in;
   qwr_type qwr;
   qrd_type qrd;
   op_type  wr_op, rd_op;
   logic    q_full, pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_PWM_PERIOD:   cfg_in.pwm_period   = csr_data;
            CSR_START_DUTY_U: cfg_in.start_duty_u = csr_data;
            CSR_START_DUTY_V: cfg_in.start_duty_v = csr_data;
            CSR_START_DUTY_W: cfg_in.start_duty_w = csr_data;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pwm_period   <= PERIOD_RST;
         cfg_ff.start_duty_u <= START_U_RST;
         cfg_ff.start_duty_v <= START_V_RST;
         cfg_ff.start_duty_w <= START_W_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ips_front u_front (
      .req_ch     (req_ch),
      .pwm_period (cfg_ff.pwm_period),
      .q_full     (q_full),
      .qwr        (qwr),
      .op         (wr_op)
   );

   ips_queue u_queue (
      .clock (clock),
      .reset (reset),
      .qwr   (qwr),
      .wr_op (wr_op),
      .full  (q_full),
      .pop   (pop),
      .qrd   (qrd),
      .rd_op (rd_op)
   );

   ips_back #(
      .COMPARE_BITS (COMPARE_BITS)
   ) u_back (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .qrd    (qrd),
      .op     (rd_op),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

   // gate and PWM enables always move together
   `ASSERT_CLK(a_gate_pwm, clock, reset, rsp_ch.valid |-> (rsp_ch.data.gate_on == rsp_ch.data.pwm_on), "gate and pwm enables differ")
   // outputs are live exactly while running
   `ASSERT_CLK(a_run_gate, clock, reset, rsp_ch.valid |-> ((rsp_ch.data.mode == M_RUNNING) == rsp_ch.data.gate_on), "gate enable out of step with running mode")
   // a latched fault and the fault mode go together
   `ASSERT_CLK(a_fault_mode, clock, reset, rsp_ch.valid |-> ((rsp_ch.data.fault_bits != '0) == (rsp_ch.data.mode == M_FAULT)), "fault mask out of step with fault mode")
   // the queue never takes an item while full
   `ASSERT_NEVER(a_no_overrun, clock, reset, req_ch.valid && req_ch.ready && q_full, "item accepted into full queue")
endmodule
`default_nettype wire
